### rtl/core/wua_pkg.sv
// wua_pkg: shared types, codes and sizes for the wide unsigned integer alu
// no dependencies; imported by every module under rtl/core
package wua_pkg;

    // operand length in 32-bit words and derived counter widths
    localparam int WORDS = 64;
    localparam int IW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = $clog2(2 * WORDS);
    localparam int KW    = $clog2(WORDS + 1);

    // command modes
    localparam logic [2:0] MODE_LOAD_A = 3'd0;
    localparam logic [2:0] MODE_LOAD_B = 3'd1;
    localparam logic [2:0] MODE_ADD    = 3'd2;
    localparam logic [2:0] MODE_SUB    = 3'd3;
    localparam logic [2:0] MODE_MUL    = 3'd4;
    localparam logic [2:0] MODE_DIV    = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_UNF   = 2'd2;
    localparam logic [1:0] ST_DZERO = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [5:0]  word_index;
        logic [31:0] word_value;
    } cmd_t;

    typedef struct packed {
        logic [5:0]  result_index;
        logic [31:0] result_word;
        logic [1:0]  status;
        logic        last;
    } res_t;

    // control of the division remainder register
    typedef struct packed {
        logic        clear;
        logic        shift;
        logic        shift_bit;
        logic        rotate;
        logic        commit;
        logic [31:0] diff_word;
    } rem_cmd_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_AS_RD,
        S_AS_EX,
        S_MUL_RD,
        S_MUL_MUL,
        S_MUL_ACC,
        S_MUL_COL,
        S_DZ_RD,
        S_DZ_CHK,
        S_DV_ARD,
        S_DV_AW,
        S_DV_SH,
        S_DV_PF,
        S_DV_TR,
        S_DV_CM,
        S_EM_RD,
        S_EM_LD,
        S_EM_WT
    } state_t;

endpackage

### rtl/core/wua_opstore.sv
// wua_opstore: one operand store, WORDS words with per-entry valid bits
// depends on wua_pkg; an entry never written reads as zero
module wua_opstore (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [wua_pkg::IW-1:0] wr_addr,
    input  logic [31:0]            wr_data,
    input  logic [wua_pkg::IW-1:0] rd_addr,
    output logic [31:0]            rd_data
);
    import wua_pkg::*;

    logic [31:0]      mem [0:WORDS-1];
    logic [WORDS-1:0] vld_reg;
    logic [31:0]      mem_q_reg;
    logic             vld_q_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            vld_q_reg <= vld_reg[rd_addr];
        end
    end

    // storage and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg <= mem[rd_addr];
    end

    assign rd_data = vld_q_reg ? mem_q_reg : 32'd0;

endmodule

### rtl/core/wua_resram.sv
// wua_resram: result store, WORDS words, contents undefined until written
// depends on wua_pkg
module wua_resram (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [wua_pkg::IW-1:0] wr_addr,
    input  logic [31:0]            wr_data,
    input  logic [wua_pkg::IW-1:0] rd_addr,
    output logic [31:0]            rd_data
);
    import wua_pkg::*;

    logic [31:0] mem [0:WORDS-1];
    logic [31:0] rd_q_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg <= mem[rd_addr];
    end

    assign rd_data = rd_q_reg;

endmodule

### rtl/core/wua_remreg.sv
// wua_remreg: division partial remainder, WORDS+1 words, plus trial difference line
// depends on wua_pkg; words circulate past position 0 where the alu sees them
module wua_remreg (
    input  logic              clk,
    input  wua_pkg::rem_cmd_t cmd,
    output logic [31:0]       rem_low
);
    import wua_pkg::*;

    logic [31:0] rem_reg  [0:WORDS];
    logic [31:0] rem_next [0:WORDS];
    logic [31:0] diff_reg  [0:WORDS];
    logic [31:0] diff_next [0:WORDS];

    // next remainder and difference line
    always_comb
    begin
        for (int k = 0; k <= WORDS; k++)
        begin
            rem_next[k]  = rem_reg[k];
            diff_next[k] = diff_reg[k];
        end
        if (cmd.clear)
        begin
            for (int k = 0; k <= WORDS; k++)
            begin
                rem_next[k] = 32'd0;
            end
        end
        else if (cmd.shift)
        begin
            rem_next[0] = {rem_reg[0][30:0], cmd.shift_bit};
            for (int k = 1; k <= WORDS; k++)
            begin
                rem_next[k] = {rem_reg[k][30:0], rem_reg[k-1][31]};
            end
        end
        else if (cmd.rotate)
        begin
            for (int k = 0; k < WORDS; k++)
            begin
                rem_next[k]  = rem_reg[k+1];
                diff_next[k] = diff_reg[k+1];
            end
            rem_next[WORDS]  = rem_reg[0];
            diff_next[WORDS] = cmd.diff_word;
        end
        else if (cmd.commit)
        begin
            for (int k = 0; k <= WORDS; k++)
            begin
                rem_next[k] = diff_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= WORDS; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            diff_reg[k] <= diff_next[k];
        end
    end

    assign rem_low = rem_reg[0];

endmodule

### rtl/core/wide_uint_alu.sv
// wide_uint_alu: top level, sequencer, shared add/subtract unit, multiplier and output register
// depends on wua_pkg, wua_opstore, wua_resram, wua_remreg
// One command word is taken at a time; cmd_ready is high only while the block is idle. Loads
// write the operand stores while the block stays idle. Add and subtract run one word pair at
// a time through the shared 33-bit adder: a read state, then an add-and-write state. Multiply
// walks the product column by column with one 32x32 multiplier: read, multiply and accumulate
// per partial product, then a column step. Divide first scans B for zero, then restores one
// quotient bit per pass of the remainder through the shared adder (shift, prefetch, trial
// subtract over every remainder word, commit). Every arithmetic operation then sends WORDS
// result words, least significant first, each via a read, a load and a wait for res_ready.
module wide_uint_alu (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  wua_pkg::cmd_t   cmd,
    output logic            res_valid,
    input  logic            res_ready,
    output wua_pkg::res_t   res
);
    import wua_pkg::*;

    localparam logic [IW-1:0] LAST_W = IW'(WORDS - 1);
    localparam logic [CW-1:0] LAST_C = CW'(2 * WORDS - 2);

    state_t state_reg, state_next;

    logic [2:0]    mode_reg, mode_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] col_reg, col_next;
    logic [IW-1:0] i_reg, i_next;
    logic [KW-1:0] k_reg, k_next;
    logic [4:0]    bit_reg, bit_next;
    logic [31:0]   abuf_reg, abuf_next;
    logic [31:0]   q_reg, q_next;
    logic          carry_reg, carry_next;
    logic          nz_reg, nz_next;
    logic          ovf_reg, ovf_next;
    logic          dzero_reg, dzero_next;
    logic [1:0]    status_reg, status_next;
    logic [95:0]   acc_reg, acc_next;
    logic [63:0]   prod_reg, prod_next;
    logic          res_valid_reg, res_valid_next;
    res_t          res_reg, res_next;

    // store ports
    logic          a_we, b_we, r_we;
    logic [IW-1:0] a_raddr, b_raddr, r_waddr, r_raddr;
    logic [31:0]   a_rd, b_rd, r_wdata, r_rd;
    logic          idx_ok;

    // shared adder
    logic [31:0]   alu_x, alu_y;
    logic          alu_sub, alu_cin;
    logic [32:0]   alu_sum;

    rem_cmd_t      rcmd;
    logic [31:0]   rem_low;

    // multiply column bounds
    function automatic logic [IW-1:0] col_lo(input logic [CW-1:0] c);
        logic [IW-1:0] r;
        if (c >= CW'(WORDS))
        begin
            r = IW'(c - CW'(WORDS - 1));
        end
        else
        begin
            r = '0;
        end
        return r;
    endfunction

    function automatic logic [IW-1:0] col_hi(input logic [CW-1:0] c);
        logic [IW-1:0] r;
        if (c < CW'(WORDS))
        begin
            r = IW'(c);
        end
        else
        begin
            r = LAST_W;
        end
        return r;
    endfunction

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // load path
    assign idx_ok = ({1'b0, cmd.word_index} < 7'(WORDS));
    assign a_we   = cmd_valid && cmd_ready && (cmd.mode == MODE_LOAD_A) && idx_ok;
    assign b_we   = cmd_valid && cmd_ready && (cmd.mode == MODE_LOAD_B) && idx_ok;

    wua_opstore u_store_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (a_we),
        .wr_addr (IW'(cmd.word_index)),
        .wr_data (cmd.word_value),
        .rd_addr (a_raddr),
        .rd_data (a_rd)
    );

    wua_opstore u_store_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (b_we),
        .wr_addr (IW'(cmd.word_index)),
        .wr_data (cmd.word_value),
        .rd_addr (b_raddr),
        .rd_data (b_rd)
    );

    wua_resram u_result (
        .clk     (clk),
        .wr_en   (r_we),
        .wr_addr (r_waddr),
        .wr_data (r_wdata),
        .rd_addr (r_raddr),
        .rd_data (r_rd)
    );

    wua_remreg u_rem (
        .clk     (clk),
        .cmd     (rcmd),
        .rem_low (rem_low)
    );

    // shared add / subtract unit
    assign alu_sum = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)} + 33'(alu_cin);

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        cnt_reg    <= cnt_next;
        col_reg    <= col_next;
        i_reg      <= i_next;
        k_reg      <= k_next;
        bit_reg    <= bit_next;
        abuf_reg   <= abuf_next;
        q_reg      <= q_next;
        carry_reg  <= carry_next;
        nz_reg     <= nz_next;
        ovf_reg    <= ovf_next;
        dzero_reg  <= dzero_next;
        status_reg <= status_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        res_reg    <= res_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        col_next       = col_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        bit_next       = bit_reg;
        abuf_next      = abuf_reg;
        q_next         = q_reg;
        carry_next     = carry_reg;
        nz_next        = nz_reg;
        ovf_next       = ovf_reg;
        dzero_next     = dzero_reg;
        status_next    = status_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        a_raddr = cnt_reg;
        b_raddr = cnt_reg;
        r_we    = 1'b0;
        r_waddr = cnt_reg;
        r_wdata = alu_sum[31:0];
        r_raddr = cnt_reg;

        alu_x   = a_rd;
        alu_y   = b_rd;
        alu_sub = (mode_reg == MODE_SUB);
        alu_cin = carry_reg;

        rcmd           = '0;
        rcmd.diff_word = alu_sum[31:0];

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    mode_next  = cmd.mode;
                    cnt_next   = '0;
                    dzero_next = 1'b0;
                    ovf_next   = 1'b0;
                    case (cmd.mode)
                        MODE_ADD:
                        begin
                            carry_next = 1'b0;
                            state_next = S_AS_RD;
                        end
                        MODE_SUB:
                        begin
                            carry_next = 1'b1;
                            state_next = S_AS_RD;
                        end
                        MODE_MUL:
                        begin
                            col_next   = '0;
                            i_next     = '0;
                            acc_next   = '0;
                            state_next = S_MUL_RD;
                        end
                        MODE_DIV:
                        begin
                            nz_next    = 1'b0;
                            state_next = S_DZ_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // add and subtract, one word pair at a time: read, then add and write
            S_AS_RD:
            begin
                state_next = S_AS_EX;
            end
            S_AS_EX:
            begin
                r_we       = 1'b1;
                carry_next = alu_sum[32];
                if (cnt_reg == LAST_W)
                begin
                    if (mode_reg == MODE_SUB)
                    begin
                        status_next = alu_sum[32] ? ST_OK : ST_UNF;
                    end
                    else
                    begin
                        status_next = alu_sum[32] ? ST_OVF : ST_OK;
                    end
                    cnt_next   = '0;
                    state_next = S_EM_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_AS_RD;
                end
            end

            // multiply, product scanning by columns
            S_MUL_RD:
            begin
                a_raddr    = i_reg;
                b_raddr    = IW'(col_reg - CW'(i_reg));
                state_next = S_MUL_MUL;
            end
            S_MUL_MUL:
            begin
                prod_next  = a_rd * b_rd;
                state_next = S_MUL_ACC;
            end
            S_MUL_ACC:
            begin
                acc_next = acc_reg + {32'd0, prod_reg};
                if (i_reg == col_hi(col_reg))
                begin
                    state_next = S_MUL_COL;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_MUL_RD;
                end
            end
            S_MUL_COL:
            begin
                r_waddr  = IW'(col_reg);
                r_wdata  = acc_reg[31:0];
                r_we     = (col_reg < CW'(WORDS));
                acc_next = {32'd0, acc_reg[95:32]};
                if (col_reg >= CW'(WORDS) && acc_reg[31:0] != 32'd0)
                begin
                    ovf_next = 1'b1;
                end
                if (col_reg == LAST_C)
                begin
                    status_next = (ovf_next || acc_reg[95:32] != 64'd0) ? ST_OVF : ST_OK;
                    cnt_next    = '0;
                    state_next  = S_EM_RD;
                end
                else
                begin
                    col_next   = col_reg + 1'b1;
                    i_next     = col_lo(col_reg + 1'b1);
                    state_next = S_MUL_RD;
                end
            end

            // divide: zero check of the divisor
            S_DZ_RD:
            begin
                state_next = S_DZ_CHK;
            end
            S_DZ_CHK:
            begin
                nz_next = nz_reg || (b_rd != 32'd0);
                if (cnt_reg == LAST_W)
                begin
                    if (!nz_next)
                    begin
                        dzero_next  = 1'b1;
                        status_next = ST_DZERO;
                        cnt_next    = '0;
                        state_next  = S_EM_RD;
                    end
                    else
                    begin
                        rcmd.clear = 1'b1;
                        cnt_next   = LAST_W;
                        state_next = S_DV_ARD;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_DZ_RD;
                end
            end

            // divide: fetch next dividend word, most significant first
            S_DV_ARD:
            begin
                state_next = S_DV_AW;
            end
            S_DV_AW:
            begin
                abuf_next  = a_rd;
                bit_next   = '0;
                state_next = S_DV_SH;
            end
            S_DV_SH:
            begin
                rcmd.shift     = 1'b1;
                rcmd.shift_bit = abuf_reg[31];
                abuf_next      = {abuf_reg[30:0], 1'b0};
                state_next     = S_DV_PF;
            end
            S_DV_PF:
            begin
                b_raddr    = '0;
                k_next     = '0;
                carry_next = 1'b1;
                state_next = S_DV_TR;
            end
            // trial subtract, one remainder word per cycle
            S_DV_TR:
            begin
                alu_x       = rem_low;
                alu_y       = (k_reg < KW'(WORDS)) ? b_rd : 32'd0;
                alu_sub     = 1'b1;
                b_raddr     = IW'(k_reg + 1'b1);
                rcmd.rotate = 1'b1;
                carry_next  = alu_sum[32];
                if (k_reg == KW'(WORDS))
                begin
                    state_next = S_DV_CM;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_DV_CM:
            begin
                rcmd.commit = carry_reg;
                q_next      = {q_reg[30:0], carry_reg};
                if (bit_reg == 5'd31)
                begin
                    r_we    = 1'b1;
                    r_waddr = cnt_reg;
                    r_wdata = q_next;
                    if (cnt_reg == '0)
                    begin
                        status_next = ST_OK;
                        state_next  = S_EM_RD;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = S_DV_ARD;
                    end
                end
                else
                begin
                    bit_next   = bit_reg + 1'b1;
                    state_next = S_DV_SH;
                end
            end

            // emit result words
            S_EM_RD:
            begin
                state_next = S_EM_LD;
            end
            S_EM_LD:
            begin
                res_next.result_index = 6'(cnt_reg);
                res_next.result_word  = dzero_reg ? 32'd0 : r_rd;
                res_next.status       = status_reg;
                res_next.last         = (cnt_reg == LAST_W);
                res_valid_next        = 1'b1;
                state_next            = S_EM_WT;
            end
            S_EM_WT:
            begin
                if (res_ready)
                begin
                    res_valid_next = 1'b0;
                    if (cnt_reg == LAST_W)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_EM_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
